// ===== src/olv_pkg.sv =====
`timescale 1ns / 1ps
package olv_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned ADDR_W      = $clog2(CAPACITY);
  localparam int unsigned IDX_W       = $clog2(CAPACITY + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

  // raw action codes
  localparam logic [2:0] A_APPEND   = 3'd0;
  localparam logic [2:0] A_DELETE   = 3'd1;
  localparam logic [2:0] A_INSERT   = 3'd2;
  localparam logic [2:0] A_READ_FWD = 3'd3;
  localparam logic [2:0] A_READ_BWD = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_DELETE,
    OP_INSERT,
    OP_READ_FWD,
    OP_READ_BWD,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [2:0]                   action;
    logic signed [DATA_WIDTH-1:0] item_value;
    logic signed [DATA_WIDTH-1:0] match_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [DATA_WIDTH-1:0] read_value;
    logic [IDX_W-1:0]             list_length;
    logic                         last_result;
  } rsp_t;

  typedef struct packed {
    op_e                   op;
    logic [DATA_WIDTH-1:0] item_value;
    logic [DATA_WIDTH-1:0] match_value;
  } job_t;

endpackage

// ===== src/ordered_value_list_engine.sv =====
`timescale 1ns / 1ps
// Append may add S_APP_LINK; delete/insert step S_RD, S_CHK per node searched, then
// S_DEL_FIX or S_INS_NODE, S_INS_LINK; reads step S_RD, S_CHK per element (node
// memory read is registered). One action at a time in the executor; a 2-entry command
// queue lets start be taken while the executor works, busy is high when it is full.
// Results are strobed for one cycle on rsp_valid_o; the receiver cannot stall.
// Reset (rst_ni low, async) empties the list: no nodes, length zero.
module ordered_value_list_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  olv_pkg::cmd_t cmd_i,
  output logic          rsp_valid_o,
  output olv_pkg::rsp_t rsp_o
);

  logic          job_valid;
  logic          job_pop;
  olv_pkg::job_t job;

  olv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  olv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== src/olv_front.sv =====
`timescale 1ns / 1ps
module olv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  olv_pkg::cmd_t     cmd_i,
  output logic              job_valid_o,
  output olv_pkg::job_t     job_o,
  input  logic              job_pop_i
);

  olv_pkg::job_t                 queue_q [olv_pkg::QUEUE_DEPTH];
  logic [olv_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [olv_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [olv_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  olv_pkg::job_t                 job_new;
  logic                          push, pop;

  always_comb begin
    job_new.item_value  = cmd_i.item_value;
    job_new.match_value = cmd_i.match_value;
    unique case (cmd_i.action)
      olv_pkg::A_APPEND:   job_new.op = olv_pkg::OP_APPEND;
      olv_pkg::A_DELETE:   job_new.op = olv_pkg::OP_DELETE;
      olv_pkg::A_INSERT:   job_new.op = olv_pkg::OP_INSERT;
      olv_pkg::A_READ_FWD: job_new.op = olv_pkg::OP_READ_FWD;
      olv_pkg::A_READ_BWD: job_new.op = olv_pkg::OP_READ_BWD;
      default:             job_new.op = olv_pkg::OP_NOP;
    endcase
  end

  assign busy        = (cnt_q == olv_pkg::QCNT_W'(olv_pkg::QUEUE_DEPTH));
  assign push        = start && !busy;
  assign job_valid_o = (cnt_q != '0);
  assign pop         = job_pop_i && job_valid_o;
  assign job_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_ONE(push) - QCNT_ONE(pop);
  end

  function automatic logic [olv_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
    QCNT_ONE = {{(olv_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

// ===== src/olv_back.sv =====
`timescale 1ns / 1ps
module olv_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  olv_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          rsp_valid_o,
  output olv_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = olv_pkg::ADDR_W;
  localparam int unsigned IW = olv_pkg::IDX_W;
  localparam int unsigned DW = olv_pkg::DATA_WIDTH;
  localparam int unsigned CAP = olv_pkg::CAPACITY;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_LINK,
    S_RD,
    S_CHK,
    S_DEL_FIX,
    S_INS_NODE,
    S_INS_LINK
  } state_e;

  state_e          state_q, state_d;
  olv_pkg::op_e    op_q, op_d;
  logic [DW-1:0]   item_q, item_d;
  logic [DW-1:0]   target_q, target_d;
  logic [IW-1:0]   p_q, p_d, pv_q, pv_d, nx_q, nx_d, slot_q, slot_d;
  logic [IW-1:0]   steps_q, steps_d;
  logic [IW-1:0]   head_q, head_d, tail_q, tail_d, count_q, count_d;
  logic [CAP-1:0]  used_q, used_d;
  logic            rsp_valid_q, rsp_valid_d;
  olv_pkg::rsp_t   rsp_q, rsp_d;

  // node storage
  logic [DW-1:0] val_mem [CAP];
  logic [IW-1:0] nxt_mem [CAP];
  logic [IW-1:0] prv_mem [CAP];
  logic [DW-1:0] val_rd_q;
  logic [IW-1:0] nxt_rd_q, prv_rd_q;

  logic          val_we, nxt_we, prv_we;
  logic [AW-1:0] val_wa, nxt_wa, prv_wa;
  logic [DW-1:0] val_wd;
  logic [IW-1:0] nxt_wd, prv_wd;

  logic [IW-1:0] free_idx;
  logic          free_ok;
  logic [IW-1:0] link;
  logic          stop;

  always_comb begin
    free_idx = olv_pkg::NIL;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign free_ok = (free_idx < olv_pkg::NIL);
  assign link    = (op_q == olv_pkg::OP_READ_BWD) ? prv_rd_q : nxt_rd_q;
  assign stop    = (link >= olv_pkg::NIL) || (steps_q == IW'(CAP - 1));

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    val_rd_q <= val_mem[p_q[AW-1:0]];
    nxt_rd_q <= nxt_mem[p_q[AW-1:0]];
    prv_rd_q <= prv_mem[p_q[AW-1:0]];
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    item_d      = item_q;
    target_d    = target_q;
    p_d         = p_q;
    pv_d        = pv_q;
    nx_d        = nx_q;
    slot_d      = slot_q;
    steps_d     = steps_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    used_d      = used_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    job_pop_o   = 1'b0;
    val_we = 1'b0; val_wa = '0; val_wd = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          op_d      = job_i.op;
          item_d    = job_i.item_value;
          steps_d   = '0;
          rsp_valid_d = 1'b1;
          rsp_d.status      = olv_pkg::ST_OK;
          rsp_d.read_value  = '0;
          rsp_d.last_result = 1'b1;
          unique case (job_i.op)
            olv_pkg::OP_APPEND: begin
              if (!free_ok) begin
                rsp_d.status = olv_pkg::ST_FULL;
              end else begin
                val_we = 1'b1; val_wa = free_idx[AW-1:0]; val_wd = job_i.item_value;
                nxt_we = 1'b1; nxt_wa = free_idx[AW-1:0]; nxt_wd = olv_pkg::NIL;
                prv_we = 1'b1; prv_wa = free_idx[AW-1:0]; prv_wd = tail_q;
                used_d[free_idx[AW-1:0]] = 1'b1;
                count_d = count_q + 1'b1;
                tail_d  = free_idx;
                if (tail_q < olv_pkg::NIL) begin
                  // old tail still needs its forward link
                  slot_d      = free_idx;
                  pv_d        = tail_q;
                  rsp_valid_d = 1'b0;
                  state_d     = S_APP_LINK;
                end else begin
                  head_d = free_idx;
                end
              end
            end
            olv_pkg::OP_DELETE, olv_pkg::OP_INSERT: begin
              if (head_q >= olv_pkg::NIL) begin
                rsp_d.status = olv_pkg::ST_EMPTY;
              end else if (job_i.op == olv_pkg::OP_INSERT && !free_ok) begin
                rsp_d.status = olv_pkg::ST_FULL;
              end else begin
                target_d = (job_i.op == olv_pkg::OP_INSERT) ? job_i.match_value
                                                            : job_i.item_value;
                slot_d      = free_idx;
                p_d         = head_q;
                rsp_valid_d = 1'b0;
                state_d     = S_RD;
              end
            end
            olv_pkg::OP_READ_FWD, olv_pkg::OP_READ_BWD: begin
              p_d = (job_i.op == olv_pkg::OP_READ_FWD) ? head_q : tail_q;
              if (p_d >= olv_pkg::NIL) begin
                rsp_d.status = olv_pkg::ST_EMPTY;
              end else begin
                rsp_valid_d = 1'b0;
                state_d     = S_RD;
              end
            end
            default: begin
            end
          endcase
          rsp_d.list_length = count_d;
        end
      end

      S_APP_LINK: begin
        nxt_we = 1'b1; nxt_wa = pv_q[AW-1:0]; nxt_wd = slot_q;
        rsp_valid_d       = 1'b1;
        rsp_d.status      = olv_pkg::ST_OK;
        rsp_d.read_value  = '0;
        rsp_d.list_length = count_q;
        rsp_d.last_result = 1'b1;
        state_d           = S_IDLE;
      end

      S_RD: begin
        state_d = S_CHK;
      end

      S_CHK: begin
        if (op_q == olv_pkg::OP_READ_FWD || op_q == olv_pkg::OP_READ_BWD) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = olv_pkg::ST_OK;
          rsp_d.read_value  = val_rd_q;
          rsp_d.list_length = count_q;
          rsp_d.last_result = stop;
          if (stop) begin
            state_d = S_IDLE;
          end else begin
            p_d     = link;
            steps_d = steps_q + 1'b1;
            state_d = S_RD;
          end
        end else if (val_rd_q == target_q) begin
          pv_d    = prv_rd_q;
          nx_d    = nxt_rd_q;
          state_d = (op_q == olv_pkg::OP_DELETE) ? S_DEL_FIX : S_INS_NODE;
        end else if (stop) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = olv_pkg::ST_NOTFOUND;
          rsp_d.read_value  = '0;
          rsp_d.list_length = count_q;
          rsp_d.last_result = 1'b1;
          state_d           = S_IDLE;
        end else begin
          p_d     = link;
          steps_d = steps_q + 1'b1;
          state_d = S_RD;
        end
      end

      S_DEL_FIX: begin
        if (pv_q < olv_pkg::NIL) begin
          nxt_we = 1'b1; nxt_wa = pv_q[AW-1:0]; nxt_wd = nx_q;
        end else begin
          head_d = nx_q;
        end
        if (nx_q < olv_pkg::NIL) begin
          prv_we = 1'b1; prv_wa = nx_q[AW-1:0]; prv_wd = pv_q;
        end else begin
          tail_d = pv_q;
        end
        used_d[p_q[AW-1:0]] = 1'b0;
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end
        rsp_valid_d       = 1'b1;
        rsp_d.status      = olv_pkg::ST_OK;
        rsp_d.read_value  = '0;
        rsp_d.list_length = count_d;
        rsp_d.last_result = 1'b1;
        state_d           = S_IDLE;
      end

      S_INS_NODE: begin
        val_we = 1'b1; val_wa = slot_q[AW-1:0]; val_wd = item_q;
        nxt_we = 1'b1; nxt_wa = slot_q[AW-1:0]; nxt_wd = p_q;
        prv_we = 1'b1; prv_wa = slot_q[AW-1:0]; prv_wd = pv_q;
        used_d[slot_q[AW-1:0]] = 1'b1;
        count_d = count_q + 1'b1;
        state_d = S_INS_LINK;
      end

      S_INS_LINK: begin
        if (pv_q < olv_pkg::NIL) begin
          nxt_we = 1'b1; nxt_wa = pv_q[AW-1:0]; nxt_wd = slot_q;
        end else begin
          head_d = slot_q;
        end
        prv_we = 1'b1; prv_wa = p_q[AW-1:0]; prv_wd = slot_q;
        rsp_valid_d       = 1'b1;
        rsp_d.status      = olv_pkg::ST_OK;
        rsp_d.read_value  = '0;
        rsp_d.list_length = count_q;
        rsp_d.last_result = 1'b1;
        state_d           = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= olv_pkg::OP_NOP;
      steps_q     <= '0;
      head_q      <= olv_pkg::NIL;
      tail_q      <= olv_pkg::NIL;
      count_q     <= '0;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      steps_q     <= steps_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      used_q      <= used_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    target_q <= target_d;
    p_q      <= p_d;
    pv_q     <= pv_d;
    nx_q     <= nx_d;
    slot_q   <= slot_d;
    rsp_q    <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== src/olv_checker.sv =====
`timescale 1ns / 1ps
module olv_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          rsp_valid_o,
  input olv_pkg::rsp_t rsp_o
);

  // a read element that is not the final one is always ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.last_result |-> rsp_o.status == olv_pkg::ST_OK)
    else $error("non-final result without ok status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status == olv_pkg::ST_EMPTY |-> rsp_o.list_length == '0)
    else $error("empty status with nonzero length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.list_length <= olv_pkg::IDX_W'(olv_pkg::CAPACITY))
    else $error("length beyond pool size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != olv_pkg::ST_OK |-> rsp_o.read_value == '0)
    else $error("value on a failed result");

endmodule

bind ordered_value_list_engine olv_checker u_olv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import olv_pkg::*;

  localparam int CAP = 64;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;

  ordered_value_list_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cmd_i(cmd_i), .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // list contents as the block should hold them, head first
  logic [DATA_WIDTH-1:0] list_vals[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic rsp_t mk_rsp(logic [1:0] st, logic [DATA_WIDTH-1:0] v, logic last);
    rsp_t r;
    r.status = st;
    r.read_value = v;
    r.list_length = IDX_W'(list_vals.size());
    r.last_result = last;
    return r;
  endfunction

  function automatic int find_first(logic [DATA_WIDTH-1:0] v);
    for (int i = 0; i < list_vals.size(); i++)
      if (list_vals[i] == v) return i;
    return -1;
  endfunction

  // advance the list for one command and queue its responses
  function automatic void predict_list(cmd_t c);
    int p;
    int n;
    n = list_vals.size();
    case (c.action)
      A_APPEND: begin
        if (n >= CAP) expected_rsps.push_back(mk_rsp(ST_FULL, '0, 1'b1));
        else begin
          list_vals.push_back(c.item_value);
          expected_rsps.push_back(mk_rsp(ST_OK, '0, 1'b1));
        end
      end
      A_DELETE: begin
        p = find_first(c.item_value);
        if (n == 0) expected_rsps.push_back(mk_rsp(ST_EMPTY, '0, 1'b1));
        else if (p < 0) expected_rsps.push_back(mk_rsp(ST_NOTFOUND, '0, 1'b1));
        else begin
          list_vals.delete(p);
          expected_rsps.push_back(mk_rsp(ST_OK, '0, 1'b1));
        end
      end
      A_INSERT: begin
        p = find_first(c.match_value);
        if (n == 0) expected_rsps.push_back(mk_rsp(ST_EMPTY, '0, 1'b1));
        else if (n >= CAP) expected_rsps.push_back(mk_rsp(ST_FULL, '0, 1'b1));
        else if (p < 0) expected_rsps.push_back(mk_rsp(ST_NOTFOUND, '0, 1'b1));
        else begin
          list_vals.insert(p, c.item_value);
          expected_rsps.push_back(mk_rsp(ST_OK, '0, 1'b1));
        end
      end
      A_READ_FWD, A_READ_BWD: begin
        if (n == 0) expected_rsps.push_back(mk_rsp(ST_EMPTY, '0, 1'b1));
        else for (int i = 0; i < n; i++)
          expected_rsps.push_back(mk_rsp(ST_OK,
            (c.action == A_READ_FWD) ? list_vals[i] : list_vals[n-1-i], i == n - 1));
      end
      default: expected_rsps.push_back(mk_rsp(ST_OK, '0, 1'b1));
    endcase
  endfunction

  task automatic send_cmd(logic [2:0] act, logic [DATA_WIDTH-1:0] iv,
                          logic [DATA_WIDTH-1:0] mv);
    cmd_t c;
    int gap;
    c.action = act;
    c.item_value = iv;
    c.match_value = mv;
    // sender bursts with random gaps; start stays high inside a burst
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    predict_list(c);
  endtask

  always @(posedge clk_i) begin
    if (rsp_valid_o) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response, actual %p", $time, rsp_o);
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (rsp_o.status !== e.status || rsp_o.read_value !== e.read_value ||
            rsp_o.list_length !== e.list_length || rsp_o.last_result !== e.last_result) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, e, rsp_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rsp_valid_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    // mostly values already in the list, so searches hit
    if (list_vals.size() > 0 && $urandom_range(0, 3) != 0)
      return list_vals[$urandom_range(0, list_vals.size() - 1)];
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send_cmd(A_DELETE, 32'd5, '0);
    send_cmd(A_INSERT, 32'd1, 32'd2);
    send_cmd(A_READ_FWD, '0, '0);
    send_cmd(A_READ_BWD, '0, '0);
  endtask

  task automatic test_edit_ops();
    send_cmd(A_APPEND, 32'h8000_0000, '0);
    send_cmd(A_APPEND, 32'h7fff_ffff, '0);
    send_cmd(A_APPEND, 32'hffff_ffff, '0);
    send_cmd(A_APPEND, 32'h0, '0);
    send_cmd(A_INSERT, 32'h1234_5678, 32'h8000_0000);
    send_cmd(A_INSERT, 32'h5555_aaaa, 32'h0);
    send_cmd(A_INSERT, 32'h1, 32'hdead_beef);
    send_cmd(A_DELETE, 32'h7777_7777, '0);
    send_cmd(A_READ_FWD, '0, '0);
    send_cmd(A_READ_BWD, '0, '0);
    send_cmd(A_DELETE, 32'h1234_5678, '0);
    send_cmd(A_DELETE, 32'h0, '0);
    send_cmd(3'd5, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(3'd6, '0, '0);
    send_cmd(3'd7, '0, '0);
    send_cmd(A_READ_FWD, '0, '0);
  endtask

  task automatic test_full_pool();
    while (list_vals.size() < CAP) send_cmd(A_APPEND, $urandom, '0);
    send_cmd(A_APPEND, 32'd9, '0);
    send_cmd(A_INSERT, 32'd9, list_vals[3]);
    send_cmd(A_READ_BWD, '0, '0);
    send_cmd(A_DELETE, list_vals[CAP-1], '0);
    send_cmd(A_INSERT, 32'hcafe_f00d, list_vals[0]);
    // drain back to a short list
    while (list_vals.size() > 4) send_cmd(A_DELETE, list_vals[$urandom_range(0, 3)], '0);
  endtask

  task automatic test_random_ops();
    int r;
    for (int i = 0; i < 190; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) send_cmd(A_APPEND, pick_value(), $urandom);
      else if (r < 52) send_cmd(A_DELETE, pick_value(), $urandom);
      else if (r < 77) send_cmd(A_INSERT, pick_value(), pick_value());
      else if (r < 86) send_cmd(A_READ_FWD, $urandom, $urandom);
      else if (r < 95) send_cmd(A_READ_BWD, $urandom, $urandom);
      else send_cmd(3'($urandom_range(5, 7)), $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edit_ops();
    test_full_pool();
    test_random_ops();
    start <= 1'b0;
    while (expected_rsps.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/olv_pkg.sv
src/olv_front.sv
src/olv_back.sv
src/ordered_value_list_engine.sv
src/olv_checker.sv
tb/tb.sv
